// ===== sv/osh_pkg.sv =====
// ----------------------------------------------------------------------------
// osh_pkg: shared definitions for the one-at-a-time string hash unit
// Register indexes, reset values, mix constants and the final mix function.
// ----------------------------------------------------------------------------
package osh_pkg;

  localparam int unsigned HashWidth   = 32;
  localparam int unsigned CharWidth   = 16;
  localparam int unsigned ShiftWidth  = 5;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDatWidth = 5;

  localparam int unsigned MixRight = 6;
  localparam int unsigned FinA     = 3;
  localparam int unsigned FinB     = 11;
  localparam int unsigned FinC     = 15;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_CHAR_MODE = 1'b0,
    REG_MIX_SHIFT = 1'b1
  } cfg_reg_t;

  localparam logic                  CharModeReset = 1'b0;
  localparam logic [ShiftWidth-1:0] MixShiftReset = 5'd10;

  typedef logic [HashWidth-1:0] hash_t;

  // final avalanche: shift-add, xor-shift, shift-add
  function automatic hash_t finalize(input hash_t h_in);
    hash_t h;
    h = h_in;
    h = h + (h << FinA);
    h = h ^ (h >> FinB);
    h = h + (h << FinC);
    return h;
  endfunction

endpackage

// ===== sv/one_at_a_time_string_hash_unit.sv =====
// ----------------------------------------------------------------------------
// one_at_a_time_string_hash_unit: streaming one-at-a-time string hash
// Three registered steps: input register, per-character mix into the
// running hash, final mix into the output register.
// ----------------------------------------------------------------------------
// A finished string's hash moves into s2, then through the final mix into
// the output register. Throughput: one item per cycle while not stalled; the
// running hash update is a loop through the add, shift-add and xor-shift.
// Stalls only when the output register is held and a finished string waits.
// Reset (rst, synchronous): empty pipeline, running hash 0, char_mode 0,
// mix_shift 10.
module one_at_a_time_string_hash_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [osh_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  logic [osh_pkg::CfgDatWidth-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [osh_pkg::CharWidth-1:0]       character,
  input  logic                                char_valid,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [osh_pkg::HashWidth-1:0]       hash
);

  logic                             char_mode;
  logic [osh_pkg::ShiftWidth-1:0]   mix_shift;

  // input register
  logic                             s1_valid;
  logic [osh_pkg::CharWidth-1:0]    s1_char;
  logic                             s1_char_valid;
  logic                             s1_last;

  // finished string awaiting final mix
  logic                             s2_valid;
  osh_pkg::hash_t                   s2_hash;

  osh_pkg::hash_t                   running_hash;
  osh_pkg::hash_t                   running_hash_next;
  osh_pkg::hash_t                   char_ext;
  osh_pkg::hash_t                   mix_add;
  osh_pkg::hash_t                   mix_shl;

  logic out_free;
  logic s2_ready;
  logic s1_consume;

  assign out_free   = !out_valid || out_ready;
  assign s2_ready   = !s2_valid || out_free;
  assign s1_consume = s1_valid && (!s1_last || s2_ready);
  assign in_ready   = !s1_valid || s1_consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_mode <= osh_pkg::CharModeReset;
      mix_shift <= osh_pkg::MixShiftReset;
    end else if (cfg_write) begin
      case (cfg_index)
        osh_pkg::REG_CHAR_MODE: char_mode <= cfg_data[0];
        osh_pkg::REG_MIX_SHIFT: mix_shift <= cfg_data[osh_pkg::ShiftWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (char_mode) begin
      char_ext = {{(osh_pkg::HashWidth-osh_pkg::CharWidth){1'b0}}, s1_char};
    end else begin
      char_ext = {{(osh_pkg::HashWidth-8){s1_char[7]}}, s1_char[7:0]};
    end
    mix_add = running_hash + char_ext;
    mix_shl = mix_add + (mix_add << mix_shift);
    if (s1_char_valid) begin
      running_hash_next = mix_shl ^ (mix_shl >> osh_pkg::MixRight);
    end else begin
      running_hash_next = running_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      out_valid    <= 1'b0;
      running_hash <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_consume) begin
        running_hash <= s1_last ? '0 : running_hash_next;
      end
      if (s2_ready) begin
        s2_valid <= s1_consume && s1_last;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_char       <= character;
      s1_char_valid <= char_valid;
      s1_last       <= last;
    end
    if (s2_ready) begin
      s2_hash <= running_hash_next;
    end
    if (out_free) begin
      hash <= osh_pkg::finalize(s2_hash);
    end
  end

endmodule

// ===== sv/osh_checker.sv =====
// ----------------------------------------------------------------------------
// osh_checker: port-level checks for the string hash unit
// Watches the handshake and stall behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module osh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [osh_pkg::HashWidth-1:0]    hash
);

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // input only backs up behind a held output
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without an output stall");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hash)))
    else $error("held result changed or dropped");

  assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result withdrawn without being taken");

endmodule

bind one_at_a_time_string_hash_unit osh_checker u_osh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hash      (hash)
);

// ===== tb/one_at_a_time_string_hash_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_at_a_time_string_hash_unit_tb: self-checking bench for the string hash
// Streams strings of characters through the unit under several register
// settings and compares every emitted hash against a cycle-free model kept in
// the bench. Both sides stall at random and the receiver holds off once for
// a long stretch so the unit backs up.
// ----------------------------------------------------------------------------
module one_at_a_time_string_hash_unit_tb;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_WIDE = 1'b1;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold = 300;

  typedef struct packed {
    logic [osh_pkg::CharWidth-1:0] chr;
    logic                          has_char;
    logic                          is_last;
  } char_item_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [osh_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [osh_pkg::CfgDatWidth-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [osh_pkg::CharWidth-1:0]   character = '0;
  logic                            char_valid = 1'b0;
  logic                            last = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  osh_pkg::hash_t                  hash;

  one_at_a_time_string_hash_unit uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .character(character), .char_valid(char_valid), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .hash(hash)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state and settings
  logic                           mode_q = osh_pkg::CharModeReset;
  logic [osh_pkg::ShiftWidth-1:0] shift_q = osh_pkg::MixShiftReset;
  osh_pkg::hash_t                 acc_hash = '0;

  char_item_t      pending[$];
  osh_pkg::hash_t  hashes_due[$];
  int              errors = 0;
  int              items_queued = 0;
  bit              sender_idle = 1'b1;
  bit              receiver_idle = 1'b1;
  int              holds_asked = 0;
  int              holds_granted = 0;
  int              send_gap = 0;
  int              recv_stall = 0;
  int              hold_left = 0;

  function automatic osh_pkg::hash_t final_mix(input osh_pkg::hash_t h_in);
    osh_pkg::hash_t h;
    h = h_in;
    h = h + (h << osh_pkg::FinA);
    h = h ^ (h >> osh_pkg::FinB);
    h = h + (h << osh_pkg::FinC);
    return h;
  endfunction

  // fold one accepted item into the running hash; queue the hash on last
  function automatic void absorb_item(input logic [osh_pkg::CharWidth-1:0] chr,
                                      input logic has_char, input logic is_last);
    osh_pkg::hash_t h;
    osh_pkg::hash_t cval;
    h = acc_hash;
    if (has_char) begin
      if (mode_q == MODE_WIDE)
        cval = {{(osh_pkg::HashWidth-osh_pkg::CharWidth){1'b0}}, chr};
      else
        cval = {{(osh_pkg::HashWidth-8){chr[7]}}, chr[7:0]};
      h = h + cval;
      h = h + (h << shift_q);
      h = h ^ (h >> osh_pkg::MixRight);
    end
    if (is_last) begin
      hashes_due.push_back(final_mix(h));
      acc_hash = '0;
    end else begin
      acc_hash = h;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    char_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready)
        absorb_item(character, char_valid, last);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          character  <= nxt.chr;
          char_valid <= nxt.has_char;
          last       <= nxt.is_last;
          in_valid   <= 1'b1;
          send_gap = sender_idle ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    osh_pkg::hash_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (hashes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected hash, expected none, actual %08h", $time, hash);
        end else begin
          want = hashes_due.pop_front();
          if (hash !== want) begin
            errors++;
            $display("%0t: hash mismatch, expected %08h, actual %08h", $time, want, hash);
          end
        end
        recv_stall = receiver_idle ? $urandom_range(0, 3) : 0;
      end
      if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic [osh_pkg::CharWidth-1:0] chr,
                            input logic has_char, input logic is_last);
    char_item_t it;
    it.chr = chr;
    it.has_char = has_char;
    it.is_last = is_last;
    pending.push_back(it);
    if (has_char || is_last)
      items_queued++;
  endtask

  // one string with random content, some noise items, some odd endings
  task automatic queue_random_string();
    int len;
    bit bare_end;
    if ($urandom_range(0, 19) == 0)
      len = 0;
    else if ($urandom_range(0, 3) == 0)
      len = $urandom_range(7, 24);
    else
      len = $urandom_range(1, 6);
    bare_end = ($urandom_range(0, 9) == 0);
    if (len == 0) begin
      queue_item(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          queue_item(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b0);
        queue_item(16'($urandom_range(0, 16'hFFFF)), 1'b1,
                   (i == len - 1) && !bare_end);
      end
      if (bare_end)
        queue_item(16'($urandom_range(0, 16'hFFFF)), 1'b0, 1'b1);
    end
  endtask

  // wait for the unit to go quiet before touching registers
  task automatic drain();
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || hashes_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input osh_pkg::cfg_reg_t idx,
                           input logic [osh_pkg::CfgDatWidth-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == osh_pkg::REG_CHAR_MODE)
      mode_q = val[0];
    else
      shift_q = val[osh_pkg::ShiftWidth-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input logic mode, input logic [osh_pkg::ShiftWidth-1:0] shift,
                              input int count, input bit idle, input bit squeeze);
    int goal;
    drain();
    // upper data bits must not leak into the mode bit
    write_reg(osh_pkg::REG_CHAR_MODE, {4'($urandom_range(0, 15)), mode});
    write_reg(osh_pkg::REG_MIX_SHIFT, shift);
    sender_idle = idle;
    receiver_idle = idle;
    if (squeeze)
      holds_asked++;
    goal = items_queued + count;
    while (items_queued < goal)
      queue_random_string();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    mode_q = osh_pkg::CharModeReset;
    shift_q = osh_pkg::MixShiftReset;
    acc_hash = '0;

    // byte mode, standard shift
    queue_item(16'h0000, 1'b0, 1'b1);   // empty string
    queue_item(16'hABCD, 1'b0, 1'b0);   // ignored
    queue_item(16'h0061, 1'b1, 1'b1);
    queue_item(16'hFF80, 1'b1, 1'b0);   // sign extension, high byte dropped
    queue_item(16'h007F, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b1, 1'b0);
    queue_item(16'hFFFF, 1'b1, 1'b1);
    queue_item(16'h1234, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b0, 1'b0);
    queue_item(16'h5678, 1'b0, 1'b1);   // bare last closes earlier chars
    queue_item(16'hFFFF, 1'b0, 1'b1);

    drain();
    write_reg(osh_pkg::REG_CHAR_MODE, {4'b0000, MODE_WIDE});
    write_reg(osh_pkg::REG_MIX_SHIFT, 5'd0);
    queue_item(16'hFFFF, 1'b1, 1'b0);
    queue_item(16'h8000, 1'b1, 1'b0);
    queue_item(16'h0000, 1'b1, 1'b1);
    queue_item(16'h0000, 1'b0, 1'b1);
    queue_item(16'h00FF, 1'b1, 1'b1);
    queue_item(16'h0080, 1'b1, 1'b0);
    queue_item(16'hFFFF, 1'b0, 1'b1);

    random_phase(MODE_BYTE, 5'd31, 250, 1'b1, 1'b0);
    random_phase(MODE_WIDE, 5'd31, 250, 1'b0, 1'b0);
    random_phase(MODE_BYTE, 5'd0,  250, 1'b1, 1'b0);
    random_phase(MODE_WIDE, 5'd10, 250, 1'b0, 1'b1);
    random_phase(MODE_BYTE, 5'd10, 250, 1'b1, 1'b0);
    random_phase(MODE_WIDE, 5'($urandom_range(0, 31)), 250, 1'b1, 1'b0);
    random_phase(MODE_BYTE, 5'($urandom_range(0, 31)), 250, 1'b1, 1'b0);
    random_phase(MODE_WIDE, 5'd0,  250, 1'b1, 1'b0);

    drain();
    if (errors == 0)
      $display("one_at_a_time_string_hash_unit test passed");
    else
      $display("one_at_a_time_string_hash_unit test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("one_at_a_time_string_hash_unit test failed");
    $finish;
  end

endmodule
